FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsfh assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsfh assertion failed");

`endif

FILE: rtl/lsfh_pkg.sv
package lsfh_pkg;

	// Host and bus commands (tuser of the input channel)
	localparam logic [2:0] CMD_BREAK = 3'd0;
	localparam logic [2:0] CMD_BYTE  = 3'd1;
	localparam logic [2:0] CMD_WDESC = 3'd2;
	localparam logic [2:0] CMD_WDATA = 3'd3;
	localparam logic [2:0] CMD_RDATA = 3'd4;

	// Frame status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SYNC   = 3'd1;
	localparam logic [2:0] ST_PARITY = 3'd2;
	localparam logic [2:0] ST_NOSLOT = 3'd3;
	localparam logic [2:0] ST_CKSUM  = 3'd4;

	// Slot roles
	localparam logic [1:0] ROLE_UNUSED = 2'd0;
	localparam logic [1:0] ROLE_PUB    = 2'd1;
	localparam logic [1:0] ROLE_SUB    = 2'd2;

	localparam logic [7:0] SYNC_PATTERN = 8'h55;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 24;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       clr_step;
		logic       desc_wr;
		logic       data_wr_host;
		logic       host_addr;
		logic       srch_start;
		logic       srch_rd;
		logic       srch_cmp;
		logic       pid_load;
		logic       pub_emit;
		logic       ck_emit;
		logic       rx_len;
		logic       rx_store;
		logic       commit_wr;
		logic       bc_clr;
		logic       host_out;
		logic       stat_emit;
		logic [2:0] stat;
	} lsfh_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       clr_last;
		logic [2:0] cmd;
		logic       sync_ok;
		logic       pid_ok;
		logic       srch_last;
		logic       found;
		logic       cur_sub;
		logic       bc_lt_n;
		logic       ck_ok;
		logic       out_free;
	} lsfh_sts_t;

	// Protected identifier: id with both parity bits on top
	function automatic logic [7:0] make_pid(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	// Carry-add: carry out of bit 7 goes back into bit 0
	function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

FILE: rtl/lin_slave_frame_handler.sv
// Channel | Handshake          | Payload
// s       | s_tvalid/s_tready  | s_tuser command, s_tdata bus byte and host fields
// m       | m_tvalid/m_tready  | m_tdata tx/status/read fields, m_tlast last
// One item at a time: s_tready is high only in the idle state. A host write
// passes the dispatch state, a read also a host read state, a data byte of a
// reception the length and decide states; an identifier byte searches all slots,
// and a status item may follow. A published byte or checksum is read, then emitted;
// a commit writes each data byte. After reset the tables are swept to zero
// with s_tready low; a stalled m side holds the controller in its emitting state.
module lin_slave_frame_handler #(
	parameter int SLOT_COUNT     = 16,
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// rx_byte, slot_index, frame_id, direction, slot length, byte_index, host_data
	input  logic [lsfh_pkg::S_DATA_W-1:0] s_tdata,
	// command
	input  logic [2:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tx_valid, tx_byte, frame_done, status, read_data
	output logic [lsfh_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	lsfh_pkg::lsfh_cmd_t cmd;
	lsfh_pkg::lsfh_sts_t sts;

	lsfh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsfh_datapath #(
		.SLOT_COUNT     (SLOT_COUNT),
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/lsfh_datapath.sv
module lsfh_datapath #(
	parameter int SLOT_COUNT     = 16,
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsfh_pkg::lsfh_cmd_t            cmd,
	output lsfh_pkg::lsfh_sts_t            sts,
	input  logic [2:0]                     s_tuser,
	input  logic [lsfh_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lsfh_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                           m_tlast
);

	localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int BW    = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
	localparam int TOTAL = SLOT_COUNT * MAX_DATA_BYTES;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int CLW   = $clog2(TOTAL + 1);
	localparam logic [3:0] MAXN = 4'(MAX_DATA_BYTES);

	// captured input item
	logic [2:0] in_cmd_q;
	logic [7:0] in_rx_q;
	logic [3:0] in_si_q;
	logic [5:0] in_fid_q;
	logic [1:0] in_dir_q;
	logic [3:0] in_len_q;
	logic [2:0] in_bi_q;
	logic [7:0] in_hd_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_cmd_q <= s_tuser;
			in_rx_q  <= s_tdata[7:0];
			in_si_q  <= s_tdata[11:8];
			in_fid_q <= s_tdata[17:12];
			in_dir_q <= s_tdata[19:18];
			in_len_q <= s_tdata[23:20];
			in_bi_q  <= s_tdata[26:24];
			in_hd_q  <= s_tdata[34:27];
		end
	end

	logic slot_ok;
	logic byte_ok;
	logic [SW-1:0] host_slot;
	assign slot_ok   = int'(in_si_q) < SLOT_COUNT;
	assign byte_ok   = slot_ok && (int'(in_bi_q) < MAX_DATA_BYTES);
	assign host_slot = SW'(in_si_q);

	// control registers
	logic [CLW-1:0] clr_q;
	logic [SW-1:0]  srch_q;
	logic [SW-1:0]  cur_slot_q;
	logic           found_q;
	logic [1:0]     cur_role_q;
	logic [3:0]     n_q;
	logic [3:0]     bc_q;
	logic [7:0]     sum_q;

	// descriptor store: {id, role, length}
	logic [11:0] desc_mem [SLOT_COUNT];
	logic [11:0] desc_rd_q;
	logic [SW-1:0] desc_raddr;
	logic [SW-1:0] desc_waddr;
	logic [11:0]   desc_wdata;
	logic          desc_we;

	assign desc_raddr = cmd.srch_rd ? srch_q : cur_slot_q;
	assign desc_we    = (cmd.clr_step && (int'(clr_q) < SLOT_COUNT)) ||
	                    (cmd.desc_wr && slot_ok);
	assign desc_waddr = cmd.clr_step ? SW'(clr_q) : host_slot;
	assign desc_wdata = cmd.clr_step ? 12'd0 : {in_fid_q, in_dir_q, in_len_q};

	always_ff @(posedge clk) begin
		if (desc_we)
			desc_mem[desc_waddr] <= desc_wdata;
		desc_rd_q <= desc_mem[desc_raddr];
	end

	logic [5:0] rd_id;
	logic [1:0] rd_role;
	logic [3:0] rd_len;
	logic [3:0] rd_n;
	assign rd_id   = desc_rd_q[11:6];
	assign rd_role = desc_rd_q[5:4];
	assign rd_len  = desc_rd_q[3:0];
	assign rd_n    = (rd_len > MAXN) ? MAXN : rd_len;

	// receive buffer
	logic [7:0] rx_buf [MAX_DATA_BYTES];
	always_ff @(posedge clk) begin
		if (cmd.rx_store)
			rx_buf[bc_q[BW-1:0]] <= in_rx_q;
	end

	// slot data store
	logic [7:0]    data_mem [TOTAL];
	logic [7:0]    data_rd_q;
	logic [SW-1:0] d_slot;
	logic [2:0]    d_idx;
	logic [AW-1:0] d_addr;
	logic          data_we;
	logic [7:0]    data_wdata;

	assign d_slot = (cmd.host_addr || cmd.data_wr_host) ? host_slot : cur_slot_q;
	assign d_idx  = (cmd.host_addr || cmd.data_wr_host) ? in_bi_q : bc_q[2:0];
	assign d_addr = cmd.clr_step ? AW'(clr_q) :
	                AW'(int'(d_slot) * MAX_DATA_BYTES + int'(d_idx));
	assign data_we = cmd.clr_step || (cmd.data_wr_host && byte_ok) || cmd.commit_wr;
	assign data_wdata = cmd.clr_step ? 8'd0 :
	                    cmd.commit_wr ? rx_buf[bc_q[BW-1:0]] : in_hd_q;

	always_ff @(posedge clk) begin
		if (data_we)
			data_mem[d_addr] <= data_wdata;
		data_rd_q <= data_mem[d_addr];
	end

	// sweep, search and frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			srch_q     <= '0;
			cur_slot_q <= '0;
			found_q    <= 1'b0;
			cur_role_q <= lsfh_pkg::ROLE_UNUSED;
			n_q        <= '0;
			bc_q       <= '0;
			sum_q      <= '0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cmd.srch_start) begin
				srch_q  <= '0;
				found_q <= 1'b0;
			end
			if (cmd.srch_cmp) begin
				srch_q <= srch_q + 1'b1;
				if ((rd_role == lsfh_pkg::ROLE_PUB || rd_role == lsfh_pkg::ROLE_SUB) &&
				    rd_id == in_rx_q[5:0]) begin
					cur_slot_q <= srch_q;
					found_q    <= 1'b1;
					cur_role_q <= rd_role;
					n_q        <= rd_n;
				end
			end
			if (cmd.rx_len)
				n_q <= rd_n;
			if (cmd.pid_load)
				sum_q <= in_rx_q;
			if (cmd.pub_emit)
				sum_q <= lsfh_pkg::carry_add(sum_q, data_rd_q);
			if (cmd.rx_store)
				sum_q <= lsfh_pkg::carry_add(sum_q, in_rx_q);
			if (cmd.bc_clr || cmd.pid_load)
				bc_q <= '0;
			else if (cmd.pub_emit || cmd.rx_store || cmd.commit_wr)
				bc_q <= bc_q + 4'd1;
		end
	end

	// output register: {read_data, status, frame_done, tx_byte, tx_valid}
	logic          out_vld_q;
	logic [20:0]   out_q;
	logic          out_last_q;
	logic          load;
	logic [20:0]   out_d;

	assign load = cmd.pub_emit || cmd.ck_emit || cmd.host_out || cmd.stat_emit;

	always_comb begin
		out_d = '0;
		if (cmd.pub_emit)
			out_d = {8'd0, 3'd0, 1'b0, data_rd_q, 1'b1};
		else if (cmd.ck_emit)
			out_d = {8'd0, lsfh_pkg::ST_OK, 1'b1, ~sum_q, 1'b1};
		else if (cmd.host_out)
			out_d = {(byte_ok ? data_rd_q : 8'd0), 3'd0, 1'b0, 8'd0, 1'b0};
		else if (cmd.stat_emit)
			out_d = {8'd0, cmd.stat, 1'b1, 8'd0, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (load)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q      <= out_d;
			out_last_q <= !cmd.pub_emit;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'd0, out_q};
	assign m_tlast  = out_last_q;

	// status to controller
	assign sts.clr_last  = int'(clr_q) == TOTAL - 1;
	assign sts.cmd       = in_cmd_q;
	assign sts.sync_ok   = in_rx_q == lsfh_pkg::SYNC_PATTERN;
	assign sts.pid_ok    = in_rx_q == lsfh_pkg::make_pid(in_rx_q[5:0]);
	assign sts.srch_last = int'(srch_q) == SLOT_COUNT - 1;
	assign sts.found     = found_q;
	assign sts.cur_sub   = cur_role_q == lsfh_pkg::ROLE_SUB;
	assign sts.bc_lt_n   = bc_q < n_q;
	assign sts.ck_ok     = in_rx_q == ~sum_q;
	assign sts.out_free  = !out_vld_q || m_tready;

endmodule

FILE: rtl/lsfh_ctrl.sv
module lsfh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  lsfh_pkg::lsfh_sts_t sts,
	output lsfh_pkg::lsfh_cmd_t cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISP     = 4'd2;
	localparam logic [3:0] S_SRCH_RD  = 4'd3;
	localparam logic [3:0] S_SRCH_CMP = 4'd4;
	localparam logic [3:0] S_SRCH_END = 4'd5;
	localparam logic [3:0] S_PUB_RD   = 4'd6;
	localparam logic [3:0] S_PUB_EMIT = 4'd7;
	localparam logic [3:0] S_PUB_CK   = 4'd8;
	localparam logic [3:0] S_RX_LEN   = 4'd9;
	localparam logic [3:0] S_RX_DEC   = 4'd10;
	localparam logic [3:0] S_COMMIT   = 4'd11;
	localparam logic [3:0] S_HOST_RD  = 4'd12;
	localparam logic [3:0] S_EMIT     = 4'd13;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SYNC = 2'd1;
	localparam logic [1:0] PH_PID  = 2'd2;
	localparam logic [1:0] PH_RECV = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic [2:0] st_q, st_d;

	assign s_tready = state_q == S_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.capture = s_tvalid && s_tready;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid)
					state_d = S_DISP;
			end
			S_DISP: begin
				cmd.host_addr = 1'b1;
				state_d = S_IDLE;
				case (sts.cmd)
					lsfh_pkg::CMD_BREAK: begin
						phase_d = PH_SYNC;
						cmd.bc_clr = 1'b1;
					end
					lsfh_pkg::CMD_BYTE: begin
						case (phase_q)
							PH_SYNC: begin
								if (sts.sync_ok) begin
									phase_d = PH_PID;
								end else begin
									phase_d = PH_IDLE;
									st_d    = lsfh_pkg::ST_SYNC;
									state_d = S_EMIT;
								end
							end
							PH_PID: begin
								phase_d = PH_IDLE;
								if (!sts.pid_ok) begin
									st_d    = lsfh_pkg::ST_PARITY;
									state_d = S_EMIT;
								end else begin
									cmd.srch_start = 1'b1;
									state_d = S_SRCH_RD;
								end
							end
							PH_RECV: state_d = S_RX_LEN;
							default: state_d = S_IDLE;
						endcase
					end
					lsfh_pkg::CMD_WDESC: cmd.desc_wr = 1'b1;
					lsfh_pkg::CMD_WDATA: cmd.data_wr_host = 1'b1;
					lsfh_pkg::CMD_RDATA: state_d = S_HOST_RD;
					default: state_d = S_IDLE;
				endcase
			end
			S_SRCH_RD: begin
				cmd.srch_rd = 1'b1;
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
				state_d = sts.srch_last ? S_SRCH_END : S_SRCH_RD;
			end
			S_SRCH_END: begin
				if (!sts.found) begin
					st_d    = lsfh_pkg::ST_NOSLOT;
					state_d = S_EMIT;
				end else begin
					cmd.pid_load = 1'b1;
					if (sts.cur_sub) begin
						phase_d = PH_RECV;
						state_d = S_IDLE;
					end else begin
						state_d = S_PUB_RD;
					end
				end
			end
			S_PUB_RD: begin
				state_d = sts.bc_lt_n ? S_PUB_EMIT : S_PUB_CK;
			end
			S_PUB_EMIT: begin
				if (sts.out_free) begin
					cmd.pub_emit = 1'b1;
					state_d = S_PUB_RD;
				end
			end
			S_PUB_CK: begin
				if (sts.out_free) begin
					cmd.ck_emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RX_LEN: begin
				cmd.rx_len = 1'b1;
				state_d = S_RX_DEC;
			end
			S_RX_DEC: begin
				if (sts.bc_lt_n) begin
					cmd.rx_store = 1'b1;
					state_d = S_IDLE;
				end else begin
					phase_d = PH_IDLE;
					cmd.bc_clr = 1'b1;
					if (sts.ck_ok) begin
						state_d = S_COMMIT;
					end else begin
						st_d    = lsfh_pkg::ST_CKSUM;
						state_d = S_EMIT;
					end
				end
			end
			S_COMMIT: begin
				if (sts.bc_lt_n) begin
					cmd.commit_wr = 1'b1;
				end else begin
					cmd.bc_clr = 1'b1;
					st_d    = lsfh_pkg::ST_OK;
					state_d = S_EMIT;
				end
			end
			S_HOST_RD: begin
				cmd.host_addr = 1'b1;
				if (sts.out_free) begin
					cmd.host_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				cmd.stat = st_q;
				if (sts.out_free) begin
					cmd.stat_emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= PH_IDLE;
			st_q    <= lsfh_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			st_q    <= st_d;
		end
	end

endmodule

FILE: rtl/lsfh_checker.sv
`include "assert_macros.svh"

module lsfh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lsfh_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	// a stalled item stays
	`CHK_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`CHK_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	// no transmit byte without tx_valid
	`CHK_IMP(a_tx_zero, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'd0)
	// status only with frame_done
	`CHK_IMP(a_st_zero, m_tvalid && !m_tdata[9], m_tdata[12:10] == lsfh_pkg::ST_OK)
	// a data byte of a response is never the last item
	`CHK_IMP(a_tx_last, m_tvalid && m_tdata[0] && !m_tdata[9], !m_tlast)

endmodule

bind lin_slave_frame_handler lsfh_checker u_lsfh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
